[design/sstf_pkg.sv]
// sstf_pkg: shared types, field widths and codes of the sstf disk request scheduler
// depends on nothing; used by the channel interfaces, controller, datapath and top level

package sstf_pkg;

   // fixed widths of the payload fields
   localparam int CYL_FIELD_W  = 13;
   localparam int SLOT_FIELD_W = 4;
   localparam int OCC_FIELD_W  = 5;

   typedef logic [CYL_FIELD_W-1:0]  cyl_type;
   typedef logic [SLOT_FIELD_W-1:0] slot_type;
   typedef logic [OCC_FIELD_W-1:0]  occ_type;

   typedef enum logic {
      OP_INSERT   = 1'b0,
      OP_DISPATCH = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_INSERTED   = 2'd0,
      STAT_DISPATCHED = 2'd1,
      STAT_FULL       = 2'd2,
      STAT_EMPTY      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // latch the accepted word and restart the scan
      logic scan;     // read one slot and step the slot counter
      logic commit;   // apply the scan result and load the response register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;  // slot counter sits on the last slot
      logic out_free;   // response register can take a word this cycle
   } ctrl_stat_type;

endpackage

[design/sstf_if.sv]
// sstf_if: valid/ready channel interfaces for request, response and csr write words
// depends on sstf_pkg

interface sstf_req_if;
   logic               valid;
   logic               ready;
   sstf_pkg::op_type   operation;
   sstf_pkg::cyl_type  cylinder;

   modport source (output valid, operation, cylinder, input ready);
   modport sink   (input valid, operation, cylinder, output ready);
endinterface

interface sstf_rsp_if;
   logic                 valid;
   logic                 ready;
   sstf_pkg::status_type status;
   sstf_pkg::slot_type   slot;
   sstf_pkg::cyl_type    served_cylinder;
   sstf_pkg::cyl_type    seek_distance;
   sstf_pkg::occ_type    occupancy;

   modport source (output valid, status, slot, served_cylinder, seek_distance, occupancy,
                   input ready);
   modport sink   (input valid, status, slot, served_cylinder, seek_distance, occupancy,
                   output ready);
endinterface

interface sstf_csr_if;
   logic               valid;
   logic               ready;
   sstf_pkg::cyl_type  data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[design/sstf_disk_request_scheduler_top.sv]
// sstf_disk_request_scheduler_top: top level of the shortest-seek-first request scheduler
// depends on sstf_pkg, sstf_if, sstf_ctrl and sstf_dpath

// Keeps up to QUEUE_DEPTH pending cylinder requests and the head position. A request
// word either inserts a cylinder into the lowest free slot (status full if none) or
// dispatches the pending request nearest the head, ties to the lowest slot (status empty
// if none); each word gives exactly one response word. A word, insert or dispatch, is
// accepted only after the previous word has been committed; the response is loaded
// into the output register at commit, which waits while an earlier response is not taken.
// The scan reads one slot per cycle through the single read port of the request
// memory into a single subtract-and-compare unit. A new request is taken while an earlier
// response still waits in the output register; csr writes set the start cylinder, used as
// the head until the first dispatch, and are taken at any time.

module sstf_disk_request_scheduler_top #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int CYLINDER_BITS = 13
) (
   input  logic              clock,
   input  logic              reset,
   sstf_req_if.sink          req_ch,
   sstf_rsp_if.source        rsp_ch,
   sstf_csr_if.sink          csr_ch
);

   // cylinders are kept at the narrower of the parameter and the field width
   localparam int CYL_W = (CYLINDER_BITS < sstf_pkg::CYL_FIELD_W) ?
                          CYLINDER_BITS : sstf_pkg::CYL_FIELD_W;

   sstf_pkg::ctrl_cmd_type  cmd;
   sstf_pkg::ctrl_stat_type stat;

   // start cylinder register, always ready for a csr word
   sstf_pkg::cyl_type start_cyl_ff;
   sstf_pkg::cyl_type start_cyl_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      start_cyl_in = start_cyl_ff;
      if (csr_ch.valid) begin
         start_cyl_in = csr_ch.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_cyl_ff <= '0;
      end else begin
         start_cyl_ff <= start_cyl_in;
      end
   end

   // sequencer: accept, scan every slot, drain the compare stage, commit
   sstf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage, compare unit and response register
   sstf_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .CYL_W       (CYL_W)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_operation       (req_ch.operation),
      .req_cylinder        (req_ch.cylinder),
      .start_cylinder      (start_cyl_ff),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_status          (rsp_ch.status),
      .rsp_slot            (rsp_ch.slot),
      .rsp_served_cylinder (rsp_ch.served_cylinder),
      .rsp_seek_distance   (rsp_ch.seek_distance),
      .rsp_occupancy       (rsp_ch.occupancy)
   );

endmodule

[design/sstf_ctrl.sv]
// sstf_ctrl: sequencer of the scheduler, accept / scan / drain / commit
// depends on sstf_pkg; drives sstf_dpath through command and status structs

module sstf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sstf_pkg::ctrl_stat_type stat,
   output sstf_pkg::ctrl_cmd_type  cmd
);

   sstf_pkg::state_type state_ff;
   sstf_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sstf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         sstf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sstf_pkg::ST_SCAN;
            end
         end
         sstf_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = sstf_pkg::ST_DRAIN;
            end
         end
         sstf_pkg::ST_DRAIN: begin
            // last slot read is compared in this cycle
            state_in = sstf_pkg::ST_COMMIT;
         end
         sstf_pkg::ST_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = sstf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sstf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[design/sstf_dpath.sv]
// sstf_dpath: request memory, slot valid bits, head register, scan compare unit
// and response register; depends on sstf_pkg, commanded by sstf_ctrl

module sstf_dpath #(
   parameter int QUEUE_DEPTH = 16,
   parameter int CYL_W       = 13
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sstf_pkg::ctrl_cmd_type  cmd,
   output sstf_pkg::ctrl_stat_type stat,
   input  sstf_pkg::op_type        req_operation,
   input  sstf_pkg::cyl_type       req_cylinder,
   input  sstf_pkg::cyl_type       start_cylinder,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output sstf_pkg::status_type    rsp_status,
   output sstf_pkg::slot_type      rsp_slot,
   output sstf_pkg::cyl_type       rsp_served_cylinder,
   output sstf_pkg::cyl_type       rsp_seek_distance,
   output sstf_pkg::occ_type       rsp_occupancy
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

   // request memory, undefined until written
   logic [CYL_W-1:0] mem_ff [QUEUE_DEPTH];

   sstf_pkg::op_type     op_ff, op_in;
   logic [CYL_W-1:0]     cyl_ff, cyl_in;
   logic [CYL_W-1:0]     head_cur_ff, head_cur_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 stage_vld_ff;
   logic [IDX_W-1:0]     stage_idx_ff;
   logic [CYL_W-1:0]     rd_cyl_ff;
   logic                 rd_vld_ff;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [CYL_W-1:0]     best_dist_ff, best_dist_in;
   logic [CYL_W-1:0]     best_cyl_ff, best_cyl_in;
   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CYL_W-1:0]     head_ff, head_in;
   logic                 known_ff, known_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   sstf_pkg::status_type rsp_status_ff, rsp_status_in;
   sstf_pkg::slot_type   rsp_slot_ff, rsp_slot_in;
   sstf_pkg::cyl_type    rsp_served_ff, rsp_served_in;
   sstf_pkg::cyl_type    rsp_dist_ff, rsp_dist_in;
   sstf_pkg::occ_type    rsp_occ_ff, rsp_occ_in;

   logic [CYL_W-1:0]     dist_up;
   logic [CYL_W-1:0]     dist_dn;
   logic [CYL_W-1:0]     seek_gap;
   logic                 take;
   logic                 ins_ok;
   logic                 disp_ok;

   // memory ports
   always_ff @(posedge clock) begin
      if (cmd.commit && ins_ok) begin
         mem_ff[best_idx_ff] <= cyl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         rd_cyl_ff <= mem_ff[idx_ff];
      end
   end

   // distance from the head to the slot just read
   always_comb begin
      dist_up  = rd_cyl_ff - head_cur_ff;
      dist_dn  = head_cur_ff - rd_cyl_ff;
      seek_gap = (rd_cyl_ff >= head_cur_ff) ? dist_up : dist_dn;
      if (op_ff == sstf_pkg::OP_INSERT) begin
         take = stage_vld_ff && !found_ff && !rd_vld_ff;
      end else begin
         take = stage_vld_ff && rd_vld_ff && (!found_ff || (seek_gap < best_dist_ff));
      end
      ins_ok  = (op_ff == sstf_pkg::OP_INSERT) && found_ff;
      disp_ok = (op_ff == sstf_pkg::OP_DISPATCH) && found_ff;
   end

   always_comb begin
      op_in        = op_ff;
      cyl_in       = cyl_ff;
      head_cur_in  = head_cur_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      best_cyl_in  = best_cyl_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      known_in     = known_ff;

      if (cmd.load) begin
         op_in       = req_operation;
         cyl_in      = req_cylinder[CYL_W-1:0];
         head_cur_in = known_ff ? head_ff : start_cylinder[CYL_W-1:0];
         idx_in      = '0;
         found_in    = 1'b0;
      end
      if (cmd.scan) begin
         idx_in = IDX_W'(idx_ff + 1'b1);
      end
      if (take) begin
         found_in     = 1'b1;
         best_idx_in  = stage_idx_ff;
         best_dist_in = seek_gap;
         best_cyl_in  = rd_cyl_ff;
      end
      if (cmd.commit) begin
         if (ins_ok) begin
            valid_in[best_idx_ff] = 1'b1;
            count_in              = CNT_W'(count_ff + 1'b1);
         end
         if (disp_ok) begin
            valid_in[best_idx_ff] = 1'b0;
            count_in              = CNT_W'(count_ff - 1'b1);
            head_in               = best_cyl_ff;
            known_in              = 1'b1;
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_served_in = rsp_served_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         case (op_ff)
            sstf_pkg::OP_INSERT:
               rsp_status_in = found_ff ? sstf_pkg::STAT_INSERTED : sstf_pkg::STAT_FULL;
            default:
               rsp_status_in = found_ff ? sstf_pkg::STAT_DISPATCHED : sstf_pkg::STAT_EMPTY;
         endcase
         rsp_slot_in   = found_ff ? sstf_pkg::slot_type'(best_idx_ff) : '0;
         rsp_served_in = disp_ok ? sstf_pkg::cyl_type'(best_cyl_ff) : '0;
         rsp_dist_in   = disp_ok ? sstf_pkg::cyl_type'(best_dist_ff) : '0;
         rsp_occ_in    = sstf_pkg::occ_type'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         known_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stage_vld_ff <= cmd.scan;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         known_ff     <= known_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      cyl_ff        <= cyl_in;
      head_cur_ff   <= head_cur_in;
      idx_ff        <= idx_in;
      stage_idx_ff  <= idx_ff;
      rd_vld_ff     <= valid_ff[idx_ff];
      found_ff      <= found_in;
      best_idx_ff   <= best_idx_in;
      best_dist_ff  <= best_dist_in;
      best_cyl_ff   <= best_cyl_in;
      head_ff       <= head_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_served_ff <= rsp_served_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign stat.scan_last = (idx_ff == IDX_LAST);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_slot            = rsp_slot_ff;
   assign rsp_served_cylinder = rsp_served_ff;
   assign rsp_seek_distance   = rsp_dist_ff;
   assign rsp_occupancy       = rsp_occ_ff;

endmodule
